>>> sv/token_bucket_rate_limiter_assert.svh
// assertion macros for the token bucket limiter checker
`ifndef TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH

// same-cycle implication, switched off while in reset
`define TBRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while in reset
`define TBRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tbrl_pkg.sv
package tbrl_pkg;

  localparam int NUM_SESSIONS    = 16;
  localparam int TOKEN_FRAC_BITS = 16;
  localparam int TIME_FRAC_BITS  = 16;
  localparam int NUM_CATS        = 5;
  localparam int NUM_BUCKETS     = NUM_SESSIONS * NUM_CATS;
  localparam int BKT_W           = $clog2(NUM_BUCKETS);

  localparam int SESS_W     = 4;
  localparam int CAT_W      = 3;
  localparam int TIME_W     = 32;
  localparam int CAP_W      = 10;
  localparam int RATE_W     = 26;
  localparam int TOK_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam int LEVEL_W = CAP_W + TOKEN_FRAC_BITS;
  localparam int PROD_W  = TIME_W + RATE_W;
  localparam int SH_L    = (TOKEN_FRAC_BITS > TIME_FRAC_BITS) ?
                           (TOKEN_FRAC_BITS - TIME_FRAC_BITS) : 0;
  localparam int SH_R    = (TIME_FRAC_BITS > TOKEN_FRAC_BITS) ?
                           (TIME_FRAC_BITS - TOKEN_FRAC_BITS) : 0;
  localparam int ADD_W   = PROD_W + SH_L;

  localparam int IN_FIELDS_W  = SESS_W + CAT_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + TOK_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CAT_W-1:0] CAT_TOUCH = CAT_W'(0);
  localparam logic [CAT_W-1:0] CAT_TEXT  = CAT_W'(1);
  localparam logic [CAT_W-1:0] CAT_MACRO = CAT_W'(2);
  localparam logic [CAT_W-1:0] CAT_OCR   = CAT_W'(3);
  localparam logic [CAT_W-1:0] CAT_AUTH  = CAT_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_CAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_CAP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MACRO_CAP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_OCR_CAP   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_CAP  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_RATE = CFG_IDX_W'(5);

  localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(64'd1 << TOKEN_FRAC_BITS);
  localparam longint GRANT_LEFT_MAX = ((longint'(1) << CAP_W) - 2) << TOKEN_FRAC_BITS;

  typedef enum logic [1:0] {
    OP_CONSUME,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BKT_W-1:0]  idx;
    logic [CAT_W-1:0]  cat;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [NUM_CATS-1:0][CAP_W-1:0] cap;
    logic [RATE_W-1:0]              auth_rate;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cap:       {CAP_W'(5), CAP_W'(2), CAP_W'(5), CAP_W'(20), CAP_W'(100)},
    auth_rate: RATE_W'(5461)
  };

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_REFILL,
    B_TAKE
  } bst_t;

endpackage

>>> sv/tbrl_front.sv
module tbrl_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,
  input  logic [tbrl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             q_full,
  output logic                             q_push,
  output tbrl_pkg::req_t                   q_wdata
);

  localparam int LIN_W = tbrl_pkg::SESS_W + tbrl_pkg::CAT_W;

  logic [tbrl_pkg::SESS_W-1:0] sess;
  logic [tbrl_pkg::CAT_W-1:0]  cat;
  logic [LIN_W-1:0]            base;
  logic                        sess_ok;
  logic                        cat_ok;

  always_comb begin
    sess    = in_tdata[tbrl_pkg::SESS_W-1:0];
    cat     = in_tdata[tbrl_pkg::SESS_W +: tbrl_pkg::CAT_W];
    base    = LIN_W'(sess) * LIN_W'(tbrl_pkg::NUM_CATS);
    sess_ok = int'(sess) < tbrl_pkg::NUM_SESSIONS;
    cat_ok  = int'(cat) < tbrl_pkg::NUM_CATS;

    q_wdata.now = in_tdata[tbrl_pkg::SESS_W + tbrl_pkg::CAT_W +: tbrl_pkg::TIME_W];
    q_wdata.cat = cat;
    q_wdata.idx = tbrl_pkg::BKT_W'(base + LIN_W'(cat));
    // a session clear points at the first of its buckets
    if (!sess_ok) begin
      q_wdata.op = tbrl_pkg::OP_NONE;
    end else if (in_tuser) begin
      q_wdata.op  = tbrl_pkg::OP_CLEAR;
      q_wdata.idx = tbrl_pkg::BKT_W'(base);
    end else if (!cat_ok) begin
      q_wdata.op = tbrl_pkg::OP_NONE;
    end else begin
      q_wdata.op = tbrl_pkg::OP_CONSUME;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

>>> sv/tbrl_queue.sv
module tbrl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tbrl_pkg::req_t wdata,
  output logic           full,
  input  logic           pop,
  output tbrl_pkg::req_t rdata,
  output logic           nonempty
);

  tbrl_pkg::req_t                 ent_r [tbrl_pkg::Q_DEPTH];
  logic [tbrl_pkg::Q_PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [tbrl_pkg::Q_PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [tbrl_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? tbrl_pkg::Q_PTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = pop  ? tbrl_pkg::Q_PTR_W'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = tbrl_pkg::Q_CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = tbrl_pkg::Q_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= wdata;
    end
  end

  assign full     = cnt_r == tbrl_pkg::Q_CNT_W'(tbrl_pkg::Q_DEPTH);
  assign nonempty = cnt_r != '0;
  assign rdata    = ent_r[rptr_r];

endmodule

>>> sv/tbrl_back.sv
module tbrl_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tbrl_pkg::req_t             q_rdata,
  output logic                       q_pop,
  input  tbrl_pkg::cfg_t             cfg,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic                       out_allowed,
  output logic [tbrl_pkg::TOK_W-1:0] out_tokens
);

  localparam int LEVEL_W = tbrl_pkg::LEVEL_W;
  localparam int MEM_W   = LEVEL_W + tbrl_pkg::TIME_W;

  tbrl_pkg::bst_t state_r, state_nxt;
  tbrl_pkg::req_t cur_r;
  logic           vld_r;

  logic [tbrl_pkg::NUM_BUCKETS-1:0] valid_r;
  logic [MEM_W-1:0]                 mem [tbrl_pkg::NUM_BUCKETS];
  logic [MEM_W-1:0]                 rd_r;

  logic [tbrl_pkg::PROD_W-1:0] prod_r;
  logic [LEVEL_W-1:0]          level_r;
  logic [LEVEL_W-1:0]          cap_q_r;
  logic                        out_valid_r;
  logic                        out_allowed_r;
  logic [tbrl_pkg::TOK_W-1:0]  out_tokens_r;

  logic                         out_free;
  logic                         mem_re, mem_we, out_load, clr_en, set_en;
  logic                         out_allowed_nxt;
  logic [tbrl_pkg::TOK_W-1:0]   out_tokens_nxt;

  logic                         is_auth;
  logic [tbrl_pkg::CAP_W-1:0]   cap_sel;
  logic [LEVEL_W-1:0]           cap_q;
  logic [tbrl_pkg::TIME_W-1:0]  elapsed;
  logic [LEVEL_W-1:0]           level0;
  logic [tbrl_pkg::RATE_W-1:0]  mul_b;
  logic [tbrl_pkg::ADD_W-1:0]   add_full;
  logic [LEVEL_W:0]             add_c;
  logic [LEVEL_W+1:0]           sum;
  logic [LEVEL_W-1:0]           refilled;
  logic                         grant;
  logic [LEVEL_W-1:0]           left;

  // bucket datapath
  always_comb begin
    is_auth = cur_r.cat == tbrl_pkg::CAT_AUTH;
    cap_sel = cfg.cap[cur_r.cat];
    cap_q   = LEVEL_W'(cap_sel) << tbrl_pkg::TOKEN_FRAC_BITS;
    // a bucket on first use starts full with no time gone by
    elapsed = vld_r ? cur_r.now - rd_r[LEVEL_W +: tbrl_pkg::TIME_W] : '0;
    level0  = vld_r ? rd_r[LEVEL_W-1:0] : cap_q;
    mul_b   = is_auth ? cfg.auth_rate : tbrl_pkg::RATE_W'(cap_sel);

    if (is_auth) begin
      add_full = tbrl_pkg::ADD_W'(prod_r >> tbrl_pkg::TIME_FRAC_BITS);
    end else begin
      add_full = (tbrl_pkg::ADD_W'(prod_r) << tbrl_pkg::SH_L) >> tbrl_pkg::SH_R;
    end
    // anything past the level width already overflows every capacity
    if (|add_full[tbrl_pkg::ADD_W-1:LEVEL_W]) begin
      add_c = (LEVEL_W + 1)'(1) << LEVEL_W;
    end else begin
      add_c = {1'b0, add_full[LEVEL_W-1:0]};
    end
    sum      = (LEVEL_W + 2)'(level_r) + (LEVEL_W + 2)'(add_c);
    refilled = (sum >= (LEVEL_W + 2)'(cap_q_r)) ? cap_q_r : sum[LEVEL_W-1:0];

    grant = level_r >= tbrl_pkg::ONE_TOKEN;
    left  = grant ? level_r - tbrl_pkg::ONE_TOKEN : level_r;
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    q_pop           = 1'b0;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    clr_en          = 1'b0;
    set_en          = 1'b0;
    out_allowed_nxt = 1'b0;
    out_tokens_nxt  = '0;
    unique case (state_r)
      tbrl_pkg::B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_rdata.op)
            tbrl_pkg::OP_CONSUME: begin
              mem_re    = 1'b1;
              state_nxt = tbrl_pkg::B_READ;
            end
            tbrl_pkg::OP_CLEAR: begin
              clr_en   = 1'b1;
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      tbrl_pkg::B_READ: begin
        state_nxt = tbrl_pkg::B_REFILL;
      end
      tbrl_pkg::B_REFILL: begin
        state_nxt = tbrl_pkg::B_TAKE;
      end
      tbrl_pkg::B_TAKE: begin
        if (out_free) begin
          mem_we          = 1'b1;
          set_en          = 1'b1;
          out_load        = 1'b1;
          out_allowed_nxt = grant;
          out_tokens_nxt  = tbrl_pkg::TOK_W'(left);
          state_nxt       = tbrl_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = tbrl_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbrl_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_en) begin
        for (int k = 0; k < tbrl_pkg::NUM_CATS; k++) begin
          valid_r[tbrl_pkg::BKT_W'(int'(q_rdata.idx) + k)] <= 1'b0;
        end
      end
      if (set_en) begin
        valid_r[cur_r.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
      vld_r <= valid_r[q_rdata.idx];
    end
    if (state_r == tbrl_pkg::B_READ) begin
      prod_r  <= tbrl_pkg::PROD_W'(elapsed) * tbrl_pkg::PROD_W'(mul_b);
      level_r <= level0;
      cap_q_r <= cap_q;
    end else if (state_r == tbrl_pkg::B_REFILL) begin
      level_r <= refilled;
    end
    if (out_load) begin
      out_allowed_r <= out_allowed_nxt;
      out_tokens_r  <= out_tokens_nxt;
    end
  end

  // bucket level and last time share one entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_r.idx] <= {cur_r.now, left};
    end
    if (mem_re) begin
      rd_r <= mem[q_rdata.idx];
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_tokens  = out_tokens_r;

endmodule

>>> sv/token_bucket_rate_limiter.sv
// consume request: bucket read, refill multiply, clamp and write-back in the back end, which
// takes no new request until the write-back, itself held while the result output is stalled
// session clear and out-of-range requests: one per cycle while the result output is not stalled
// a 2-entry request queue lets input acceptance run ahead of the back end
// reset (rst_n low, synchronous) marks every bucket unused and restores default capacities
module token_bucket_rate_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,   // [0] mode
  input  logic [tbrl_pkg::IN_TDATA_W-1:0]     in_tdata,   // [3:0] session, [6:4] category,
                                                          // [38:7] now_time
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tbrl_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] allowed, [26:1] tokens_left
  input  logic                                cfg_we,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tbrl_pkg::cfg_t             cfg_r, cfg_nxt;
  tbrl_pkg::req_t             q_wdata, q_rdata;
  logic                       q_push, q_pop, q_full, q_valid;
  logic                       out_allowed;
  logic [tbrl_pkg::TOK_W-1:0] out_tokens;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tbrl_pkg::CFG_TOUCH_CAP:
          cfg_nxt.cap[tbrl_pkg::CAT_TOUCH] = cfg_wdata[tbrl_pkg::CAP_W-1:0];
        tbrl_pkg::CFG_TEXT_CAP:
          cfg_nxt.cap[tbrl_pkg::CAT_TEXT] = cfg_wdata[tbrl_pkg::CAP_W-1:0];
        tbrl_pkg::CFG_MACRO_CAP:
          cfg_nxt.cap[tbrl_pkg::CAT_MACRO] = cfg_wdata[tbrl_pkg::CAP_W-1:0];
        tbrl_pkg::CFG_OCR_CAP:
          cfg_nxt.cap[tbrl_pkg::CAT_OCR] = cfg_wdata[tbrl_pkg::CAP_W-1:0];
        tbrl_pkg::CFG_AUTH_CAP:
          cfg_nxt.cap[tbrl_pkg::CAT_AUTH] = cfg_wdata[tbrl_pkg::CAP_W-1:0];
        tbrl_pkg::CFG_AUTH_RATE:
          cfg_nxt.auth_rate = cfg_wdata[tbrl_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tbrl_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tbrl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tbrl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_valid)
  );

  tbrl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .cfg         (cfg_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_allowed (out_allowed),
    .out_tokens  (out_tokens)
  );

  assign out_tdata = tbrl_pkg::OUT_TDATA_W'({out_tokens, out_allowed});

endmodule

>>> sv/tbrl_checker.sv
`include "token_bucket_rate_limiter_assert.svh"

module tbrl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tbrl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `TBRL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  `TBRL_ASSERT_NOW(a_quiet_after_reset, $past(!rst_n), !out_tvalid, "result shown straight after reset")

  // a grant took one token from at most a full bucket
  `TBRL_ASSERT_NOW(a_grant_left, out_tvalid && out_tdata[0], out_tdata[tbrl_pkg::TOK_W:1] <= tbrl_pkg::GRANT_LEFT_MAX, "grant leaves more than capacity less one")

  // a denial only happens below one token
  `TBRL_ASSERT_NOW(a_deny_left, out_tvalid && !out_tdata[0], out_tdata[tbrl_pkg::TOK_W:1] < tbrl_pkg::ONE_TOKEN, "denied with a whole token left")

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
